// ===== sv/fxl_pkg.sv =====
package fxl_pkg;

  // Default list depth
  localparam int unsigned DEPTH_DEF = 8;

  localparam int unsigned VALUE_W = 32;

  // Operation codes on the op port
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_POS   = 3'd1,
    OP_APPEND    = 3'd2,
    OP_INS_SORT  = 3'd3,
    OP_REM_VALUE = 3'd4,
    OP_REM_FRONT = 3'd5,
    OP_REM_BACK  = 3'd6,
    OP_CLEAR     = 3'd7
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // What each cell does with its entry this cycle
  typedef enum logic [1:0] {
    KIND_HOLD,
    KIND_INSERT,
    KIND_REMOVE
  } kind_t;

  // How a cell decides it is the target of the operation
  typedef enum logic [1:0] {
    MODE_INDEX,
    MODE_GE,
    MODE_EQ
  } mode_t;

  // Command broadcast to every cell
  typedef struct packed {
    kind_t                     kind;
    mode_t                     mode;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== sv/fxl_cell.sv =====
module fxl_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 4
) (
  input  logic                               clk,
  input  fxl_pkg::cell_cmd_t                 cmd,
  input  logic [CW-1:0]                      entry_count,
  input  logic [CW-1:0]                      target,
  input  logic signed [fxl_pkg::VALUE_W-1:0] left_entry,
  input  logic signed [fxl_pkg::VALUE_W-1:0] right_entry,
  input  logic                               prefix_in,
  output logic                               prefix_out,
  output logic signed [fxl_pkg::VALUE_W-1:0] entry
);

  localparam logic [CW-1:0] MY_IDX  = CW'(INDEX);
  localparam logic [CW-1:0] NXT_IDX = CW'(INDEX + 1);

  logic in_list;
  logic hit;
  logic at_target;

  // Local target detection, then hand the "seen" flag to the next cell
  always_comb begin
    in_list = MY_IDX < entry_count;
    unique case (cmd.mode)
      fxl_pkg::MODE_INDEX: hit = (MY_IDX == target);
      fxl_pkg::MODE_GE:    hit = (in_list && !(entry < cmd.value)) || (MY_IDX == entry_count);
      fxl_pkg::MODE_EQ:    hit = in_list && (entry == cmd.value);
      default:             hit = 1'b0;
    endcase
    prefix_out = prefix_in | hit;
    at_target  = hit & ~prefix_in;
  end

  // Entry update: take the new value, shift up from the left or down from the right
  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      fxl_pkg::KIND_INSERT: begin
        if (at_target) begin
          entry <= cmd.value;
        end else if (prefix_in && (MY_IDX <= entry_count)) begin
          entry <= left_entry;
        end
      end
      fxl_pkg::KIND_REMOVE: begin
        if (prefix_out && (NXT_IDX < entry_count)) begin
          entry <= right_entry;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/fixed_array_list_engine_unit.sv =====
// Ordered list engine built as a row of entry cells.
// The command register holds each accepted command, the cell row executes it, and done
// and the result are then registered in the count and result registers.
// Throughput: one command per cycle; busy stays low, the next command may follow at once.
// The cell row compares, searches and shifts all entries within the execute cycle.
// Reset (rst, synchronous) empties the list and drops any pending result; the receiver
// cannot stall and must take each result in the one cycle done is high.
module fixed_array_list_engine_unit #(
  parameter int unsigned DEPTH = fxl_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         op,
  input  logic signed [fxl_pkg::VALUE_W-1:0] value,
  input  logic [3:0]                         position,
  output logic                               done,
  output logic                               ok,
  output logic [2:0]                         status,
  output logic [3:0]                         count,
  output logic                               full_res,
  output logic                               empty_res
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = CW + 4;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [WW-1:0] LAST_W  = WW'(DEPTH - 1);

  // Registered command
  logic                               c_valid;
  fxl_pkg::op_t                       c_op;
  logic signed [fxl_pkg::VALUE_W-1:0] c_value;
  logic [3:0]                         c_pos;

  logic [CW-1:0] entry_count;
  logic [CW-1:0] entry_count_next;

  fxl_pkg::cell_cmd_t cmd;
  logic [CW-1:0]      target;
  fxl_pkg::status_t   st;
  logic               is_full;
  logic               is_empty;
  logic [WW-1:0]      pos_w;
  logic [WW-1:0]      cnt_w;
  logic [WW-1:0]      cnt_next_w;
  fxl_pkg::status_t   res_st;
  logic [CW-1:0]      res_count;

  logic signed [fxl_pkg::VALUE_W-1:0] entries [DEPTH];
  logic [DEPTH:0]                     prefix;

  assign busy = 1'b0;

  // Command register
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= start & ~busy;
    end
    if (start && !busy) begin
      c_op    <= fxl_pkg::op_t'(op);
      c_value <= value;
      c_pos   <= position;
    end
  end

  // Decode: cell command, target index, status and next count
  always_comb begin
    is_full          = entry_count >= DEPTH_C;
    is_empty         = entry_count == '0;
    pos_w            = WW'(c_pos);
    cnt_w            = WW'(entry_count);
    cmd.kind         = fxl_pkg::KIND_HOLD;
    cmd.mode         = fxl_pkg::MODE_INDEX;
    cmd.value        = c_value;
    target           = '0;
    st               = fxl_pkg::ST_OK;
    entry_count_next = entry_count;
    unique case (c_op)
      fxl_pkg::OP_INS_FRONT, fxl_pkg::OP_APPEND, fxl_pkg::OP_INS_SORT: begin
        if (is_full) begin
          st = fxl_pkg::ST_FULL;
        end else begin
          cmd.kind         = fxl_pkg::KIND_INSERT;
          entry_count_next = entry_count + 1'b1;
          if (c_op == fxl_pkg::OP_INS_SORT) begin
            cmd.mode = fxl_pkg::MODE_GE;
          end else if (c_op == fxl_pkg::OP_APPEND) begin
            target = entry_count;
          end
        end
      end
      fxl_pkg::OP_INS_POS: begin
        if (is_full) begin
          st = fxl_pkg::ST_FULL;
        end else if (pos_w > LAST_W) begin
          st = fxl_pkg::ST_BADPOS;
        end else begin
          cmd.kind         = fxl_pkg::KIND_INSERT;
          entry_count_next = entry_count + 1'b1;
          target           = (pos_w >= cnt_w) ? entry_count : pos_w[CW-1:0];
        end
      end
      fxl_pkg::OP_REM_VALUE: begin
        cmd.mode = fxl_pkg::MODE_EQ;
        if (is_empty) begin
          st = fxl_pkg::ST_EMPTY;
        end else begin
          // a miss is resolved below from the cell row's search
          cmd.kind         = fxl_pkg::KIND_REMOVE;
          entry_count_next = entry_count - 1'b1;
        end
      end
      fxl_pkg::OP_REM_FRONT, fxl_pkg::OP_REM_BACK: begin
        if (is_empty) begin
          st = fxl_pkg::ST_EMPTY;
        end else begin
          entry_count_next = entry_count - 1'b1;
          if (c_op == fxl_pkg::OP_REM_FRONT) begin
            cmd.kind = fxl_pkg::KIND_REMOVE;
          end
        end
      end
      fxl_pkg::OP_CLEAR: entry_count_next = '0;
      default: begin
      end
    endcase
    if (!c_valid) begin
      cmd.kind         = fxl_pkg::KIND_HOLD;
      entry_count_next = entry_count;
    end
  end

  // Remove by value: no matching cell means not found and no count change
  always_comb begin
    res_st    = st;
    res_count = entry_count_next;
    if ((c_op == fxl_pkg::OP_REM_VALUE) && !is_empty && !prefix[DEPTH]) begin
      res_st    = fxl_pkg::ST_NOTFOUND;
      res_count = entry_count;
    end
    cnt_next_w = WW'(res_count);
  end

  // Row of entry cells
  assign prefix[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [fxl_pkg::VALUE_W-1:0] left_e;
    logic signed [fxl_pkg::VALUE_W-1:0] right_e;

    if (i == 0) begin : g_first
      assign left_e = c_value;
    end else begin : g_mid_l
      assign left_e = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_mid_r
      assign right_e = entries[i+1];
    end

    fxl_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .entry_count (entry_count),
      .target      (target),
      .left_entry  (left_e),
      .right_entry (right_e),
      .prefix_in   (prefix[i]),
      .prefix_out  (prefix[i+1]),
      .entry       (entries[i])
    );
  end

  // Count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      entry_count <= res_count;
      done        <= c_valid;
    end
    ok        <= (res_st == fxl_pkg::ST_OK);
    status    <= res_st;
    count     <= cnt_next_w[3:0];
    full_res  <= (res_count == DEPTH_C);
    empty_res <= (res_count == '0);
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= DEPTH_C)
    else $error("entry count exceeds depth");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (ok == (status == fxl_pkg::ST_OK)))
    else $error("ok disagrees with status");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(full_res && empty_res))
    else $error("full and empty both set");

  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (entry_count == $past(entry_count)))
    else $error("failed operation changed the count");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("transfer did not produce a result");

endmodule
